// ===== rtl/core/mfhf_pkg.sv =====
// Shared types, constants and decode tables for the MP3 frame header finder.
package mfhf_pkg;

  localparam logic [7:0] SYNC_BYTE   = 8'hFF;
  localparam logic [3:0] SYNC_NIBBLE = 4'hF;
  localparam logic [3:0] LAYER3_A    = 4'hA;
  localparam logic [3:0] LAYER3_B    = 4'hB;

  typedef enum logic [1:0] {
    PH_SCAN  = 2'd0,
    PH_BYTE3 = 2'd1,
    PH_BYTE4 = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic        is_layer3;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic        copyrighted;
    logic        original_media;
    logic [31:0] header_word;
  } out_word_t;

  function automatic logic [8:0] bitrate_lookup(input logic [3:0] idx);
    logic [8:0] kbps;
    case (idx)
      4'd1:    kbps = 9'd32;
      4'd2:    kbps = 9'd40;
      4'd3:    kbps = 9'd48;
      4'd4:    kbps = 9'd56;
      4'd5:    kbps = 9'd64;
      4'd6:    kbps = 9'd80;
      4'd7:    kbps = 9'd96;
      4'd8:    kbps = 9'd112;
      4'd9:    kbps = 9'd128;
      4'd10:   kbps = 9'd160;
      4'd11:   kbps = 9'd192;
      4'd12:   kbps = 9'd224;
      4'd13:   kbps = 9'd256;
      4'd14:   kbps = 9'd320;
      default: kbps = 9'd0;
    endcase
    return kbps;
  endfunction

  function automatic logic [15:0] sample_rate_lookup(input logic [1:0] code);
    logic [15:0] hz;
    case (code)
      2'd0:    hz = 16'd44100;
      2'd1:    hz = 16'd48000;
      2'd2:    hz = 16'd32000;
      default: hz = 16'd0;
    endcase
    return hz;
  endfunction

endpackage

// ===== rtl/core/mfhf_stream_if.sv =====
// Valid/ready stream channel carrying one payload word per handshake.
interface mfhf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/mp3_frame_header_finder.sv =====
// Latency: a result word is valid in the cycle after the byte that completes it is accepted.
// Throughput: one byte per cycle, set by the single decode stage ahead of the output register.
// A new byte is accepted while the output register is empty or being drained.
// Reset (rst, synchronous) returns the scanner to searching and empties the output register.
// Top level of the MP3 frame header finder.
module mp3_frame_header_finder (
  input logic          clk,
  input logic          rst,
  mfhf_stream_if.sink   in_ch,
  mfhf_stream_if.source out_ch
);

  mfhf_pkg::phase_t    phase;
  mfhf_pkg::phase_t    phase_next;
  logic                last_sync;
  logic                last_sync_next;
  logic [7:0]          second_byte;
  logic [7:0]          second_byte_next;
  logic [7:0]          third_byte;
  logic [7:0]          third_byte_next;
  logic                out_valid;
  mfhf_pkg::out_word_t out_data;
  mfhf_pkg::out_word_t result;
  logic                emit;
  logic                in_accept;
  logic [7:0]          b;
  logic [3:0]          lay;

  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;
  assign b            = in_ch.data.data_byte;
  assign lay          = second_byte[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= mfhf_pkg::PH_SCAN;
      last_sync   <= 1'b0;
      second_byte <= 8'd0;
      third_byte  <= 8'd0;
    end else begin
      phase       <= phase_next;
      last_sync   <= last_sync_next;
      second_byte <= second_byte_next;
      third_byte  <= third_byte_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    last_sync_next   = last_sync;
    second_byte_next = second_byte;
    third_byte_next  = third_byte;
    emit             = 1'b0;
    result           = '0;
    if (in_accept) begin
      case (phase)
        mfhf_pkg::PH_SCAN: begin
          if (last_sync && b[7:4] == mfhf_pkg::SYNC_NIBBLE) begin
            second_byte_next = b;
            last_sync_next   = 1'b0;
            phase_next       = mfhf_pkg::PH_BYTE3;
          end else begin
            last_sync_next = (b == mfhf_pkg::SYNC_BYTE);
          end
        end
        mfhf_pkg::PH_BYTE3: begin
          third_byte_next = b;
          phase_next      = mfhf_pkg::PH_BYTE4;
        end
        mfhf_pkg::PH_BYTE4: begin
          emit                  = 1'b1;
          result.found          = 1'b1;
          result.is_layer3      = (lay == mfhf_pkg::LAYER3_A) || (lay == mfhf_pkg::LAYER3_B);
          result.bitrate_kbps   = mfhf_pkg::bitrate_lookup(third_byte[7:4]);
          result.sample_rate_hz = mfhf_pkg::sample_rate_lookup(third_byte[3:2]);
          result.copyrighted    = b[3];
          result.original_media = b[2];
          result.header_word    = {mfhf_pkg::SYNC_BYTE, second_byte, third_byte, b};
          phase_next            = mfhf_pkg::PH_DONE;
        end
        default: begin
        end
      endcase
      if (in_ch.data.end_of_stream) begin
        // A stream that ends without a reported header yields an all-zero word.
        if (!emit && phase_next != mfhf_pkg::PH_DONE) begin
          emit   = 1'b1;
          result = '0;
        end
        phase_next       = mfhf_pkg::PH_SCAN;
        last_sync_next   = 1'b0;
        second_byte_next = 8'd0;
        third_byte_next  = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      out_data <= result;
    end
  end

  a_rearm: assert property (@(posedge clk) disable iff (rst)
    in_accept && in_ch.data.end_of_stream |=> phase == mfhf_pkg::PH_SCAN && !last_sync)
    else $error("scanner not re-armed after end of stream");

  a_found_sync: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.found |-> out_data.header_word[31:20] == 12'hFFF)
    else $error("found word without frame sync");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data == '0)
    else $error("not-found word carries nonzero fields");

  a_one_report: assert property (@(posedge clk) disable iff (rst)
    in_accept && phase == mfhf_pkg::PH_DONE |=> !(out_valid && !$past(out_valid)))
    else $error("word emitted while ignoring bytes");

endmodule
